FILE: hw/rtl/psmh_pkg.sv
// ============================================================================
// psmh_pkg
// Shared sizes, operation and status codes and the stored entry format of the
// pair score min-heap.
// ============================================================================
package psmh_pkg;

    // Store sizing
    localparam int HEAP_DEPTH = 1024;
    localparam int MAX_ORDER  = 32;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

    // Field widths
    localparam int OP_W       = 2;
    localparam int KEY_W      = 32;
    localparam int TAG_W      = 10;
    localparam int ORDER_W    = 6;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int DIV_CNT_W  = $clog2(TAG_W + 1);

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(32);

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD   = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // One heap slot: signed Q16.16 key plus flat matrix position
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } entry_t;

endpackage

FILE: hw/rtl/pair_score_min_heap.sv
// ============================================================================
// pair_score_min_heap
// Sequence: append, refused ops and unused codes pass from the input beat
//   through the response state to the result. Extract reads root and last entry,
//   sinks that entry from the root (at most 9 levels), then divides the root tag
//   bit-serially. Build sifts each index from count/2 down to 0.
// Throughput: one item at a time, set by the single-entry sift loop around the
//   heap memory (two reads, one write); a new beat is taken while a result waits.
// Reset: async active low; entry count cleared, order reads 32, memory not cleared.
// ============================================================================
module pair_score_min_heap
    import psmh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input item channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [KEY_W-1:0]    score_key,
    input  logic [TAG_W-1:0]           position_tag,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ROW_W-1:0]           row_index,
    output logic [COL_W-1:0]           column_index,
    output logic [STATUS_W-1:0]        status,
    // configuration write channel (matrix order)
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ORDER_W-1:0]         cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_RESP     = 8'b0000_0010,
        S_EXT_RD   = 8'b0000_0100,
        S_BUILD_RD = 8'b0000_1000,
        S_FETCH    = 8'b0001_0000,
        S_SIFT_RD  = 8'b0010_0000,
        S_SIFT_CMP = 8'b0100_0000,
        S_DIV      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // control state
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     node_reg;
    logic [IDX_W-1:0]     build_idx_reg;
    logic                 is_build_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [ORDER_W-1:0]   order_reg;
    logic                 out_valid_reg;

    // payload
    entry_t               cur_reg;
    logic [TAG_W-1:0]     div_quot_reg;
    logic [COL_W-1:0]     div_rem_reg;
    logic [ROW_W-1:0]     res_row_reg;
    logic [COL_W-1:0]     res_col_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    // heap memory: one write port, two registered read ports
    entry_t               heap_mem [HEAP_DEPTH];
    entry_t               rd_a_reg;
    entry_t               rd_b_reg;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic                 rd_en_a;
    logic [IDX_W-1:0]     rd_addr_a;
    logic                 rd_en_b;
    logic [IDX_W-1:0]     rd_addr_b;

    logic                 in_accept;
    logic                 store_full;
    logic                 heap_empty;
    logic [IDX_W+1:0]     left_idx;
    logic [IDX_W+1:0]     right_idx;
    logic [IDX_W+1:0]     count_ext;
    logic                 left_ok;
    logic                 right_ok;
    logic                 take_left;
    logic                 take_right;
    logic signed [KEY_W-1:0] best_key;
    logic                 sift_end;
    logic                 resp_load;
    logic [ORDER_W-1:0]   order_eff;
    logic [ORDER_W-1:0]   div_trial;
    logic                 div_ge;
    logic [ORDER_W-1:0]   div_diff;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_accept    = in_valid && in_ready;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign row_index    = out_row_reg;
    assign column_index = out_col_reg;
    assign status       = out_status_reg;

    assign store_full = (count_reg >= CNT_W'(HEAP_DEPTH));
    assign heap_empty = (count_reg == '0);
    assign resp_load  = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    // child indices of the current node
    assign left_idx  = {1'b0, node_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign count_ext = (IDX_W + 2)'(count_reg);
    assign left_ok   = (left_idx < count_ext);
    assign right_ok  = (right_idx < count_ext);

    // child selection: strict less keeps parent on ties, left wins equal children
    assign take_left  = ($signed(rd_a_reg.key) < $signed(cur_reg.key));
    assign best_key   = take_left ? rd_a_reg.key : cur_reg.key;
    assign take_right = right_ok && ($signed(rd_b_reg.key) < best_key);

    // effective divisor: zero acts as one, large values clamp
    always_comb
    begin
        if (order_reg == '0)
        begin
            order_eff = ORDER_W'(1);
        end
        else if (order_reg > ORDER_W'(MAX_ORDER))
        begin
            order_eff = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            order_eff = order_reg;
        end
    end

    // one restoring division step per cycle
    assign div_trial = {div_rem_reg, div_quot_reg[TAG_W-1]};
    assign div_ge    = (div_trial >= order_eff);
    assign div_diff  = div_trial - order_eff;

    // sequencer and memory port control
    always_comb
    begin
        state_next = state_reg;
        wr_en      = 1'b0;
        wr_addr    = node_reg;
        wr_data    = cur_reg;
        rd_en_a    = 1'b0;
        rd_addr_a  = '0;
        rd_en_b    = 1'b0;
        rd_addr_b  = '0;
        sift_end   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (operation)
                        OP_APPEND:
                        begin
                            if (!store_full)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = count_reg[IDX_W-1:0];
                                wr_data = '{key: score_key, tag: position_tag};
                            end
                            state_next = S_RESP;
                        end
                        OP_BUILD:   state_next = S_BUILD_RD;
                        OP_EXTRACT: state_next = heap_empty ? S_RESP : S_EXT_RD;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_EXT_RD:
            begin
                // root tag on port A, last entry on port B
                rd_en_a    = 1'b1;
                rd_addr_a  = '0;
                rd_en_b    = 1'b1;
                rd_addr_b  = IDX_W'(count_reg - 1'b1);
                state_next = S_FETCH;
            end
            S_BUILD_RD:
            begin
                if (CNT_W'(build_idx_reg) >= count_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en_a    = 1'b1;
                    rd_addr_a  = build_idx_reg;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_SIFT_RD;
            end
            S_SIFT_RD:
            begin
                if (left_ok)
                begin
                    rd_en_a    = 1'b1;
                    rd_addr_a  = left_idx[IDX_W-1:0];
                    rd_en_b    = 1'b1;
                    rd_addr_b  = right_idx[IDX_W-1:0];
                    state_next = S_SIFT_CMP;
                end
                else
                begin
                    wr_en    = 1'b1;
                    sift_end = 1'b1;
                end
            end
            S_SIFT_CMP:
            begin
                wr_en = 1'b1;
                if (take_right)
                begin
                    wr_data    = rd_b_reg;
                    state_next = S_SIFT_RD;
                end
                else if (take_left)
                begin
                    wr_data    = rd_a_reg;
                    state_next = S_SIFT_RD;
                end
                else
                begin
                    sift_end = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(TAG_W))
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // end of one sift: next build index, the response after index 0, or on to the divider
        if (sift_end)
        begin
            if (!is_build_reg)
            begin
                state_next = S_DIV;
            end
            else if (build_idx_reg == '0)
            begin
                state_next = S_RESP;
            end
            else
            begin
                state_next = S_BUILD_RD;
            end
        end
    end

    // heap memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en_a)
        begin
            rd_a_reg <= heap_mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rd_b_reg <= heap_mem[rd_addr_b];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            node_reg      <= '0;
            build_idx_reg <= '0;
            is_build_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            order_reg     <= ORDER_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                order_reg <= cfg_data;
            end

            // output beat handshake
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_accept)
            begin
                is_build_reg  <= (operation == OP_BUILD);
                build_idx_reg <= IDX_W'(count_reg >> 1);
                if ((operation == OP_APPEND) && !store_full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            // start of a sift
            if (state_reg == S_FETCH)
            begin
                div_cnt_reg <= '0;
                if (is_build_reg)
                begin
                    node_reg <= build_idx_reg;
                end
                else
                begin
                    node_reg  <= '0;
                    count_reg <= count_reg - 1'b1;
                end
            end

            // descend into the winning child
            if (state_reg == S_SIFT_CMP)
            begin
                if (take_right)
                begin
                    node_reg <= right_idx[IDX_W-1:0];
                end
                else if (take_left)
                begin
                    node_reg <= left_idx[IDX_W-1:0];
                end
            end

            if (sift_end && is_build_reg && (build_idx_reg != '0))
            begin
                build_idx_reg <= build_idx_reg - 1'b1;
            end

            if ((state_reg == S_DIV) && (div_cnt_reg != DIV_CNT_W'(TAG_W)))
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_row_reg <= '0;
            res_col_reg <= '0;
            if ((operation == OP_APPEND) && store_full)
            begin
                res_status_reg <= STATUS_FULL;
            end
            else if ((operation == OP_EXTRACT) && heap_empty)
            begin
                res_status_reg <= STATUS_EMPTY;
            end
            else
            begin
                res_status_reg <= STATUS_DONE;
            end
        end

        // moving entry and dividend
        if (state_reg == S_FETCH)
        begin
            cur_reg <= is_build_reg ? rd_a_reg : rd_b_reg;
            if (!is_build_reg)
            begin
                div_quot_reg <= rd_a_reg.tag;
                div_rem_reg  <= '0;
            end
        end

        if (state_reg == S_DIV)
        begin
            if (div_cnt_reg != DIV_CNT_W'(TAG_W))
            begin
                div_quot_reg <= {div_quot_reg[TAG_W-2:0], div_ge};
                div_rem_reg  <= COL_W'(div_ge ? div_diff : div_trial);
            end
            else
            begin
                res_row_reg <= ROW_W'(div_quot_reg);
                res_col_reg <= div_rem_reg;
            end
        end

        if (resp_load)
        begin
            out_row_reg    <= res_row_reg;
            out_col_reg    <= res_col_reg;
            out_status_reg <= res_status_reg;
        end
    end

endmodule

FILE: hw/rtl/psmh_checker.sv
// ============================================================================
// psmh_checker
// Port-level checks of the pair score min-heap: result beats match accepted
// items, refused results carry no position, positions fit the matrix order.
// ============================================================================
module psmh_checker
    import psmh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [ROW_W-1:0]        row_index,
    input  logic [COL_W-1:0]        column_index,
    input  logic [STATUS_W-1:0]     status,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [ORDER_W-1:0]      cfg_data
);

    logic [1:0]         pending_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [ORDER_W-1:0] order_eff;
    logic [15:0]        flat_pos;
    logic               in_beat;
    logic               out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // items accepted but not yet delivered, and the order in force
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            order_reg   <= ORDER_RESET;
        end
        else
        begin
            if (in_beat && !out_beat)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (!in_beat && out_beat)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (order_reg == '0)
        begin
            order_eff = ORDER_W'(1);
        end
        else if (order_reg > ORDER_W'(MAX_ORDER))
        begin
            order_eff = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            order_eff = order_reg;
        end
    end

    assign flat_pos = 16'(row_index) * 16'(order_eff) + 16'(column_index);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_index)
            && $stable(column_index) && $stable(status))
        else $error("result beat changed while stalled");

    // no result without an item behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result beat with no accepted item");

    // at most one item in work plus one waiting result
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many items outstanding");

    // refused results (status not done) carry a zero position
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_DONE) |-> row_index == '0 && column_index == '0)
        else $error("refused result with nonzero position");

    // column fits the matrix order and the flat position fits the tag range
    a_pos_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (6'(column_index) < order_eff) && (flat_pos < 16'(1 << TAG_W)))
        else $error("position outside matrix order");

endmodule

bind pair_score_min_heap psmh_checker u_psmh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_index    (row_index),
    .column_index (column_index),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
);
